FILE: hw/rtl/ipv4hc_pkg.sv
// Shared types, constants and functions for the IPv4 header check block.
`timescale 1ns / 1ps

package ipv4hc_pkg;

  localparam int unsigned HeaderBytes    = 20;
  localparam int unsigned MaxPacketBytes = 65535;

  localparam logic [15:0] HEADER_BYTES     = 16'(HeaderBytes);
  localparam logic [15:0] MAX_PACKET_BYTES = 16'(MaxPacketBytes);

  localparam logic [15:0] IDX_IHL      = 16'd0;
  localparam logic [15:0] IDX_LEN_HI   = 16'd2;
  localparam logic [15:0] IDX_LEN_LO   = 16'd3;
  localparam logic [15:0] IDX_TTL      = 16'd8;
  localparam logic [15:0] IDX_PROTO    = 16'd9;
  localparam logic [15:0] IDX_CSUM_HI  = 16'd10;
  localparam logic [15:0] IDX_CSUM_LO  = 16'd11;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_BAD_SUM = 2'd2,
    ST_TRUNC   = 2'd3
  } status_e;

  typedef struct packed {
    logic [19:0] sum;
    logic [15:0] count;
    logic [15:0] rx_csum;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [15:0] total_len;
    logic [3:0]  hdr_words;
  } snap_t;

  function automatic logic [15:0] fold_invert(input logic [20:0] s);
    logic [16:0] t;
    logic [16:0] u;
    t = {1'b0, s[15:0]} + {12'd0, s[20:16]};
    u = {1'b0, t[15:0]} + {16'd0, t[16]};
    return ~u[15:0];
  endfunction

endpackage

FILE: hw/rtl/ipv4hc_accum.sv
// Per-byte header capture, checksum accumulation and packet snapshot.
`timescale 1ns / 1ps

module ipv4hc_accum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_i,
  output logic                snap_valid_o,
  input  logic                snap_ready_i,
  output ipv4hc_pkg::snap_t   snap_o
);

  logic [15:0] count_q, count_d;
  logic [19:0] sum_q, sum_d;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] rx_csum_q, rx_csum_d;
  logic [7:0]  ttl_q, ttl_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] total_len_q, total_len_d;
  logic [3:0]  hdr_words_q, hdr_words_d;
  logic        snap_vld_q;
  ipv4hc_pkg::snap_t snap_q;
  logic        accept;
  logic [7:0]  v;

  assign in_ready_o   = !snap_vld_q || snap_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign snap_valid_o = snap_vld_q;
  assign snap_o       = snap_q;

  always_comb begin
    count_d     = count_q;
    sum_d       = sum_q;
    hold_d      = hold_q;
    rx_csum_d   = rx_csum_q;
    ttl_d       = ttl_q;
    proto_d     = proto_q;
    total_len_d = total_len_q;
    hdr_words_d = hdr_words_q;
    v           = data_byte_i;
    if (count_q < ipv4hc_pkg::HEADER_BYTES) begin
      if (count_q == ipv4hc_pkg::IDX_IHL)     hdr_words_d = data_byte_i[3:0];
      if (count_q == ipv4hc_pkg::IDX_LEN_HI)  total_len_d[15:8] = data_byte_i;
      if (count_q == ipv4hc_pkg::IDX_LEN_LO)  total_len_d[7:0] = data_byte_i;
      if (count_q == ipv4hc_pkg::IDX_TTL)     ttl_d = data_byte_i;
      if (count_q == ipv4hc_pkg::IDX_PROTO)   proto_d = data_byte_i;
      if (count_q == ipv4hc_pkg::IDX_CSUM_HI) begin
        rx_csum_d[15:8] = data_byte_i;
        v = 8'd0;
      end
      if (count_q == ipv4hc_pkg::IDX_CSUM_LO) begin
        rx_csum_d[7:0] = data_byte_i;
        v = 8'd0;
      end
      if (!count_q[0]) begin
        hold_d = v;
      end else begin
        sum_d = sum_q + {4'd0, hold_q, v};
      end
    end
    if (count_q < ipv4hc_pkg::MAX_PACKET_BYTES) begin
      count_d = count_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sum_q       <= '0;
      hold_q      <= '0;
      rx_csum_q   <= '0;
      ttl_q       <= '0;
      proto_q     <= '0;
      total_len_q <= '0;
      hdr_words_q <= '0;
      snap_vld_q  <= 1'b0;
    end else begin
      if (accept && last_i) begin
        count_q     <= '0;
        sum_q       <= '0;
        hold_q      <= '0;
        rx_csum_q   <= '0;
        ttl_q       <= '0;
        proto_q     <= '0;
        total_len_q <= '0;
        hdr_words_q <= '0;
      end else if (accept) begin
        count_q     <= count_d;
        sum_q       <= sum_d;
        hold_q      <= hold_d;
        rx_csum_q   <= rx_csum_d;
        ttl_q       <= ttl_d;
        proto_q     <= proto_d;
        total_len_q <= total_len_d;
        hdr_words_q <= hdr_words_d;
      end
      if (accept && last_i) begin
        snap_vld_q <= 1'b1;
      end else if (snap_ready_i) begin
        snap_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_i) begin
      snap_q.sum       <= sum_d;
      snap_q.count     <= count_d;
      snap_q.rx_csum   <= rx_csum_d;
      snap_q.ttl       <= ttl_d;
      snap_q.proto     <= proto_d;
      snap_q.total_len <= total_len_d;
      snap_q.hdr_words <= hdr_words_d;
    end
  end

endmodule

FILE: hw/rtl/ipv4hc_result.sv
// Header verdict, TTL decrement and checksum update into the result register.
`timescale 1ns / 1ps

module ipv4hc_result (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                snap_valid_i,
  output logic                snap_ready_o,
  input  ipv4hc_pkg::snap_t   snap_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic signed [16:0]  payload_length_o,
  output logic [7:0]          new_ttl_o,
  output logic [15:0]         new_checksum_o
);

  logic                  out_vld_q;
  ipv4hc_pkg::status_e   status_q, status_d;
  logic signed [16:0]    plen_q, plen_d;
  logic [7:0]            nttl_q, nttl_d;
  logic [15:0]           nsum_q, nsum_d;
  logic                  take;
  logic [7:0]            dec_ttl;
  logic [20:0]           upd_sum;
  logic [16:0]           diff_len;

  assign snap_ready_o = !out_vld_q || out_ready_i;
  assign take         = snap_valid_i && snap_ready_o;

  assign dec_ttl  = snap_i.ttl - 8'd1;
  assign upd_sum  = {1'b0, snap_i.sum} - {5'd0, snap_i.ttl, snap_i.proto}
                  + {5'd0, dec_ttl, snap_i.proto};
  assign diff_len = {1'b0, snap_i.total_len} - {11'd0, snap_i.hdr_words, 2'b00};

  always_comb begin
    status_d = ipv4hc_pkg::ST_OK;
    plen_d   = '0;
    nttl_d   = '0;
    nsum_d   = '0;
    if (snap_i.count < ipv4hc_pkg::HEADER_BYTES) begin
      status_d = ipv4hc_pkg::ST_SHORT;
    end else if (ipv4hc_pkg::fold_invert({1'b0, snap_i.sum}) != snap_i.rx_csum) begin
      status_d = ipv4hc_pkg::ST_BAD_SUM;
    end else begin
      nttl_d = dec_ttl;
      nsum_d = ipv4hc_pkg::fold_invert(upd_sum);
      if (snap_i.count < snap_i.total_len) begin
        status_d = ipv4hc_pkg::ST_TRUNC;
      end else begin
        plen_d = signed'(diff_len);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      plen_q   <= plen_d;
      nttl_q   <= nttl_d;
      nsum_q   <= nsum_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = status_q;
  assign payload_length_o = plen_q;
  assign new_ttl_o        = nttl_q;
  assign new_checksum_o   = nsum_q;

endmodule

FILE: hw/rtl/ipv4_header_check_ttl_update_top.sv
// Top level of the IPv4 header check and TTL update block.
`timescale 1ns / 1ps

// Takes an IPv4 packet one byte per cycle with last_i on the final byte and
// returns one result per packet: status, payload length, decremented TTL and
// the recomputed header checksum. A byte is accepted every cycle while the
// single snapshot slot between the byte accumulator and the result register
// is free or draining. The snapshot of the last byte is registered first and
// then moves into the result register. Bytes beyond 65535 are counted as 65535.
module ipv4_header_check_ttl_update_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [16:0] payload_length_o,
  output logic [7:0]         new_ttl_o,
  output logic [15:0]        new_checksum_o
);

  logic              snap_valid;
  logic              snap_ready;
  ipv4hc_pkg::snap_t snap;

  ipv4hc_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_i       (last_i),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  ipv4hc_result u_result (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .snap_valid_i     (snap_valid),
    .snap_ready_o     (snap_ready),
    .snap_i           (snap),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .payload_length_o (payload_length_o),
    .new_ttl_o        (new_ttl_o),
    .new_checksum_o   (new_checksum_o)
  );

`ifndef SYNTHESIS
  a_last_snap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_i) |=> snap_valid)
    else $error("last byte accepted without a packet snapshot");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ipv4hc_pkg::ST_SHORT ||
                     status_o == ipv4hc_pkg::ST_BAD_SUM))
    |-> (new_ttl_o == 8'd0 && new_checksum_o == 16'd0))
    else $error("ttl or checksum set on a rejected header");

  a_plen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ipv4hc_pkg::ST_OK) |-> (payload_length_o == 17'sd0))
    else $error("payload length set on a non-ok result");

  a_no_stall_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_valid && !snap_ready) |-> (out_valid_o && !out_ready_i))
    else $error("snapshot held while the result register is free");
`endif

endmodule

FILE: tb/ipv4_header_check_ttl_update_top_tb.sv
// Testbench for the IPv4 header check and TTL update block: directed and random packets.
`timescale 1ns / 1ps

module ipv4_header_check_ttl_update_top_tb;

  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned PhaseBytes  = 240;
  localparam int unsigned DrainCycles = 10;

  typedef struct packed {
    ipv4hc_pkg::status_e st;
    logic signed [16:0]  plen;
    logic [7:0]          ttl;
    logic [15:0]         csum;
  } verdict_t;

  typedef struct packed {
    logic [16:0]         nbytes;
    logic [7:0]          b0;
    logic [15:0]         tot;
    logic [7:0]          ttl;
    logic [7:0]          proto;
    logic [7:0]          fill;
    bit                  sum_ok;
    bit                  typed;
    ipv4hc_pkg::status_e st;
    logic signed [16:0]  plen;
    logic [7:0]          ettl;
    logic [15:0]         ecs;
  } probe_row_t;

  probe_row_t probe_rows [11] = '{
    '{17'd1,  8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, ipv4hc_pkg::ST_SHORT,
      17'sd0, 8'd0,   16'h0000},
    '{17'd19, 8'h45, 16'd19,   8'h40, 8'h06, 8'hA5, 1'b1, 1'b1, ipv4hc_pkg::ST_SHORT,
      17'sd0, 8'd0,   16'h0000},
    '{17'd20, 8'h00, 16'd0,    8'h00, 8'h00, 8'h00, 1'b1, 1'b1, ipv4hc_pkg::ST_OK,
      17'sd0, 8'd255, 16'h00FF},
    '{17'd20, 8'h45, 16'd20,   8'h00, 8'h11, 8'h5A, 1'b1, 1'b0, ipv4hc_pkg::ST_OK,
      17'sd0, 8'd0,   16'h0000},
    '{17'd40, 8'h45, 16'd40,   8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, ipv4hc_pkg::ST_OK,
      17'sd0, 8'd0,   16'h0000},
    '{17'd24, 8'h45, 16'd24,   8'h40, 8'h06, 8'h3C, 1'b0, 1'b1, ipv4hc_pkg::ST_BAD_SUM,
      17'sd0, 8'd0,   16'h0000},
    '{17'd30, 8'h45, 16'd100,  8'h80, 8'h01, 8'h77, 1'b1, 1'b0, ipv4hc_pkg::ST_OK,
      17'sd0, 8'd0,   16'h0000},
    '{17'd60, 8'h4F, 16'd60,   8'h01, 8'h06, 8'hC3, 1'b1, 1'b0, ipv4hc_pkg::ST_OK,
      17'sd0, 8'd0,   16'h0000},
    '{17'd20, 8'h4F, 16'd8,    8'h40, 8'h06, 8'h00, 1'b1, 1'b0, ipv4hc_pkg::ST_OK,
      17'sd0, 8'd0,   16'h0000},
    '{17'd21, 8'hF0, 16'd21,   8'h02, 8'h00, 8'h0F, 1'b1, 1'b0, ipv4hc_pkg::ST_OK,
      17'sd0, 8'd0,   16'h0000},
    '{17'd20, 8'h0F, 16'd0,    8'h80, 8'h80, 8'h80, 1'b1, 1'b0, ipv4hc_pkg::ST_OK,
      17'sd0, 8'd0,   16'h0000}
  };

  int unsigned send_pct [4] = '{0, 83, 0, 33};
  int unsigned recv_pct [4] = '{0, 0, 83, 33};

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i  = 8'h00;
  logic               last_i       = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [1:0]         status_o;
  logic signed [16:0] payload_length_o;
  logic [7:0]         new_ttl_o;
  logic [15:0]        new_checksum_o;

  verdict_t    expected_verdicts [$];
  logic [7:0]  pkt_q [$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned err_cnt        = 0;
  int unsigned bytes_sent     = 0;
  int unsigned packets_sent   = 0;
  int unsigned longest_pkt    = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};

  // header tracker state
  logic [15:0] hc_count;
  logic [19:0] hc_sum;
  logic [7:0]  hc_hi;
  logic [15:0] hc_rx_csum;
  logic [7:0]  hc_ttl;
  logic [7:0]  hc_proto;
  logic [15:0] hc_total;
  logic [3:0]  hc_words;

  ipv4_header_check_ttl_update_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .payload_length_o (payload_length_o),
    .new_ttl_o        (new_ttl_o),
    .new_checksum_o   (new_checksum_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [15:0] inet_csum(input logic [31:0] s);
    logic [31:0] t;
    t = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
    return ~t[15:0];
  endfunction

  task automatic clear_header_state();
    hc_count   = '0;
    hc_sum     = '0;
    hc_hi      = '0;
    hc_rx_csum = '0;
    hc_ttl     = '0;
    hc_proto   = '0;
    hc_total   = '0;
    hc_words   = '0;
  endtask

  task automatic predict_header_byte(input logic [7:0] b, input logic is_last,
                                     output bit has_res, output verdict_t res);
    logic [7:0]  v;
    logic [7:0]  nttl;
    logic [31:0] s;
    v       = b;
    has_res = 1'b0;
    res     = '0;
    if (hc_count < ipv4hc_pkg::HEADER_BYTES) begin
      case (hc_count)
        ipv4hc_pkg::IDX_IHL:     hc_words = b[3:0];
        ipv4hc_pkg::IDX_LEN_HI:  hc_total[15:8] = b;
        ipv4hc_pkg::IDX_LEN_LO:  hc_total[7:0] = b;
        ipv4hc_pkg::IDX_TTL:     hc_ttl = b;
        ipv4hc_pkg::IDX_PROTO:   hc_proto = b;
        ipv4hc_pkg::IDX_CSUM_HI: begin
          hc_rx_csum[15:8] = b;
          v = 8'h00;
        end
        ipv4hc_pkg::IDX_CSUM_LO: begin
          hc_rx_csum[7:0] = b;
          v = 8'h00;
        end
        default: ;
      endcase
      if (!hc_count[0]) hc_hi = v;
      else hc_sum = hc_sum + {4'd0, hc_hi, v};
    end
    if (hc_count < ipv4hc_pkg::MAX_PACKET_BYTES) hc_count = hc_count + 16'd1;
    if (is_last) begin
      has_res = 1'b1;
      if (hc_count < ipv4hc_pkg::HEADER_BYTES) begin
        res.st = ipv4hc_pkg::ST_SHORT;
      end else if (inet_csum({12'd0, hc_sum}) != hc_rx_csum) begin
        res.st = ipv4hc_pkg::ST_BAD_SUM;
      end else begin
        nttl     = hc_ttl - 8'd1;
        s        = {12'd0, hc_sum} - {16'd0, hc_ttl, hc_proto} + {16'd0, nttl, hc_proto};
        res.ttl  = nttl;
        res.csum = inet_csum(s);
        if (hc_count < hc_total) begin
          res.st = ipv4hc_pkg::ST_TRUNC;
        end else begin
          res.st   = ipv4hc_pkg::ST_OK;
          res.plen = 17'(int'(hc_total) - 4 * int'(hc_words));
        end
      end
      clear_header_state();
    end
  endtask

  task automatic build_packet(input int nbytes, input logic [7:0] b0, input logic [15:0] tot,
                              input logic [7:0] ttl, input logic [7:0] proto,
                              input logic [7:0] fill, input bit rnd, input bit good);
    logic [31:0] acc;
    logic [15:0] cs;
    pkt_q.delete();
    for (int i = 0; i < nbytes; i++) pkt_q.push_back(rnd ? 8'($urandom) : fill);
    pkt_q[0] = b0;
    if (nbytes > 3) begin
      pkt_q[2] = tot[15:8];
      pkt_q[3] = tot[7:0];
    end
    if (nbytes > 9) begin
      pkt_q[8] = ttl;
      pkt_q[9] = proto;
    end
    if (nbytes >= 20) begin
      acc = '0;
      for (int w = 0; w < 10; w++) begin
        if (w != 5) acc = acc + {16'd0, pkt_q[2 * w], pkt_q[2 * w + 1]};
      end
      cs = inet_csum(acc);
      if (!good) cs = cs ^ 16'h0101;
      pkt_q[10] = cs[15:8];
      pkt_q[11] = cs[7:0];
    end
  endtask

  task automatic send_packet(input bit typed, input verdict_t typed_res);
    bit       has_res;
    verdict_t res;
    for (int i = 0; i < pkt_q.size(); i++) begin
      if ($urandom_range(99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
      end
      in_valid_i  <= 1'b1;
      data_byte_i <= pkt_q[i];
      last_i      <= (i == pkt_q.size() - 1);
      do @(posedge clk_i); while (!in_ready_o);
      predict_header_byte(pkt_q[i], i == pkt_q.size() - 1, has_res, res);
      if (has_res) expected_verdicts.push_back(typed ? typed_res : res);
      bytes_sent++;
      @(negedge clk_i);
    end
    packets_sent++;
    if (pkt_q.size() > longest_pkt) longest_pkt = pkt_q.size();
  endtask

  task automatic random_packet();
    int unsigned kind;
    int unsigned n;
    logic [15:0] tot;
    logic [7:0]  b0;
    kind = $urandom_range(0, 9);
    b0   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h45;
    if (kind < 2) begin
      n = $urandom_range(1, 19);
      build_packet(int'(n), 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 8'h00,
                   1'b1, 1'b1);
    end else begin
      n = $urandom_range(20, 60);
      case ($urandom_range(0, 5))
        0:       tot = 16'(n + $urandom_range(1, 40));
        1:       tot = 16'($urandom);
        2:       tot = 16'($urandom_range(0, n - 1));
        default: tot = 16'(n);
      endcase
      build_packet(int'(n), b0, tot, 8'($urandom), 8'($urandom), 8'h00, 1'b1, kind != 2);
    end
    send_packet(1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_verdicts.size() != 0);
  endtask

  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      status_seen[status_o]++;
      if (expected_verdicts.size() == 0) begin
        $error("result with no expectation pending: status %0d", status_o);
        err_cnt++;
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (status_o != exp_v.st) begin
          $error("status: expected %0d, got %0d", exp_v.st, status_o);
          err_cnt++;
        end
        if (payload_length_o != exp_v.plen) begin
          $error("payload_length: expected %0d, got %0d", exp_v.plen, payload_length_o);
          err_cnt++;
        end
        if (new_ttl_o != exp_v.ttl) begin
          $error("new_ttl: expected %0d, got %0d", exp_v.ttl, new_ttl_o);
          err_cnt++;
        end
        if (new_checksum_o != exp_v.csum) begin
          $error("new_checksum: expected %h, got %h", exp_v.csum, new_checksum_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               expected_verdicts.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    verdict_t    typed_v;
    int unsigned phase_start;
    clear_header_state();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < $size(probe_rows); r++) begin
      build_packet(int'(probe_rows[r].nbytes), probe_rows[r].b0, probe_rows[r].tot,
                   probe_rows[r].ttl, probe_rows[r].proto, probe_rows[r].fill, 1'b0,
                   probe_rows[r].sum_ok);
      typed_v.st   = probe_rows[r].st;
      typed_v.plen = probe_rows[r].plen;
      typed_v.ttl  = probe_rows[r].ettl;
      typed_v.csum = probe_rows[r].ecs;
      send_packet(probe_rows[r].typed, typed_v);
    end
    wait_drained();

    // hold the output off while short requests pile up behind it
    hold_req = 400;
    for (int k = 0; k < 40; k++) begin
      build_packet(1, 8'($urandom), 16'h0000, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
      send_packet(1'b0, '0);
    end
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      phase_start    = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) random_packet();
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d packets (%0d bytes, longest %0d) over four idle/stall mixes.",
             packets_sent, bytes_sent, longest_pkt);
    $display("Results seen: ok %0d, short %0d, bad checksum %0d, truncated %0d.",
             status_seen[ipv4hc_pkg::ST_OK], status_seen[ipv4hc_pkg::ST_SHORT],
             status_seen[ipv4hc_pkg::ST_BAD_SUM], status_seen[ipv4hc_pkg::ST_TRUNC]);
    if (err_cnt == 0 && expected_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
